>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define MNS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition is followed by another in the next cycle
`define MNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mns_pkg.sv
`default_nettype none

package mns_pkg;

    // Field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 10;
    localparam int FREQ_W = 16;
    localparam int DUR_W  = 16;
    localparam int CNT_W  = 11;
    localparam int PS_W   = 2;

    // Table depth, a power of two
    localparam int MAX_NOTES_DEF = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_PLAYING = 3'b010,
        ST_BETWEEN = 3'b100
    } t_state;

    // Reported player state codes
    localparam logic [PS_W-1:0] PS_IDLE    = 2'd0;
    localparam logic [PS_W-1:0] PS_PLAYING = 2'd1;
    localparam logic [PS_W-1:0] PS_BETWEEN = 2'd2;

    // Event flag bit positions
    localparam int EV_START = 0;
    localparam int EV_STOP  = 1;
    localparam int EV_TMO   = 2;
    localparam int EV_END   = 3;

    typedef struct packed {
        t_op                operation;
        logic [IDX_W-1:0]   note_index;
        logic [FREQ_W-1:0]  note_frequency;
        logic [DUR_W-1:0]   note_duration;
    } t_note_item;

    typedef struct packed {
        logic [FREQ_W-1:0]  tone_frequency;
        logic [PS_W-1:0]    player_state;
        logic [IDX_W-1:0]   note_position;
    } t_result_item;

    // One table entry as stored in the note memory
    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [DUR_W-1:0]   dur;
    } t_note;

endpackage

`default_nettype wire

>>> rtl/mns_if.sv
`default_nettype none

interface mns_note_if;
    import mns_pkg::*;

    logic       valid;
    logic       ready;
    t_note_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mns_result_if;
    import mns_pkg::*;

    logic         valid;
    logic         ready;
    t_result_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/mns_ram.sv
`default_nettype none

module mns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port, old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/mns_out_buf.sv
`default_nettype none
`include "assert_macros.svh"

module mns_out_buf (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire mns_pkg::t_result_item i_data,
    output logic                       o_ready,
    mns_result_if.source               o_res
);
    import mns_pkg::*;

    t_result_item r_ent [2];
    t_result_item n_ent [2];
    logic [1:0]   r_cnt;
    logic [1:0]   n_cnt;
    logic         r_rdy;
    logic         w_pop;
    logic         w_slot;

    assign w_pop         = o_res.valid && o_res.ready;
    assign o_res.valid   = (r_cnt != 2'd0);
    assign o_res.payload = r_ent[0];
    assign o_ready       = r_rdy;

    // Shift on pop, write the new item behind the ones held
    always_comb begin
        n_ent  = r_ent;
        w_slot = w_pop ? 1'(r_cnt - 2'd1) : r_cnt[0];
        if (w_pop) begin
            n_ent[0] = r_ent[1];
        end
        if (i_push) begin
            n_ent[w_slot] = i_data;
        end
        n_cnt = r_cnt + 2'(i_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rdy <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rdy <= (n_cnt != 2'd2);
        end
    end

    `MNS_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "output buffer count out of range")
    `MNS_ASSERT(a_rdy_room, i_clk, i_rst_n, !r_rdy || (r_cnt != 2'd2), "ready with a full buffer")

endmodule

`default_nettype wire

>>> rtl/melody_note_sequencer_unit.sv
// An accepted item's result enters the two-entry output buffer and is offered on
// o_res behind any results still held; the buffer lets input go on while a result
// waits. One item per cycle while the buffer has room; the next note is prefetched
// from the note memory (one read port, registered read), note 0 kept in registers.
// Reset (synchronous, active low): player idle, silent, position and timer zero,
// note_count 1; the note tables are undefined until written.
`default_nettype none
`include "assert_macros.svh"

module melody_note_sequencer_unit #(
    parameter int MAX_NOTES = mns_pkg::MAX_NOTES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [mns_pkg::CNT_W-1:0] i_cfg_data,
    mns_note_if.sink                       i_note,
    mns_result_if.source                   o_res
);
    import mns_pkg::*;

    localparam int AW = $clog2(MAX_NOTES);
    localparam int CW = (AW > CNT_W) ? AW : CNT_W;

    // Player state
    t_state              r_state,    n_state;
    logic [3:0]          r_flags,    n_flags;
    logic [AW-1:0]       r_pos,      n_pos;
    t_note               r_cur,      n_cur;
    logic [FREQ_W-1:0]   r_tone,     n_tone;
    logic [DUR_W-1:0]    r_tmr,      n_tmr;
    logic                r_tmr_run,  n_tmr_run;
    logic [CNT_W-1:0]    r_note_count;

    // Note memory support
    t_note               r_note0;
    logic                r_fwd_hit;
    t_note               r_fwd_data;
    logic [2*FREQ_W-1:0] w_ram_q;
    logic [AW-1:0]       w_raddr;
    logic [AW-1:0]       w_idx;
    logic [AW-1:0]       w_next_addr;
    t_note               w_wdata;
    t_note               w_note0;
    t_note               w_next;
    logic                w_acc;
    logic                w_wr;
    logic                w_buf_rdy;
    t_note_item          w_item;
    t_result_item        w_res;

    assign w_item         = i_note.payload;
    assign i_note.ready   = w_buf_rdy;
    assign w_acc          = i_note.valid && i_note.ready;
    assign w_wr           = w_acc && (w_item.operation == OP_WRITE);
    assign w_idx          = AW'(w_item.note_index);
    assign w_wdata        = {w_item.note_frequency, w_item.note_duration};
    assign w_next_addr    = r_pos + AW'(1);

    // Note 0 and the next note, with forwarding of writes in flight
    always_comb begin
        w_note0 = (w_wr && (w_idx == '0)) ? w_wdata : r_note0;
        w_next  = r_fwd_hit ? r_fwd_data : t_note'(w_ram_q);
        if (w_wr && (w_idx == w_next_addr)) begin
            w_next = w_wdata;
        end
    end

    // Apply the event, then fire at most one transition
    always_comb begin
        n_state   = r_state;
        n_flags   = r_flags;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_tone    = r_tone;
        n_tmr     = r_tmr;
        n_tmr_run = r_tmr_run;
        if (w_acc) begin
            unique case (w_item.operation)
                OP_TICK: begin
                    if (r_tmr_run) begin
                        if (r_tmr != '1) begin
                            n_tmr = r_tmr + DUR_W'(1);
                        end
                        if (n_tmr >= r_cur.dur) begin
                            n_flags[EV_TMO] = 1'b1;
                            n_tmr_run       = 1'b0;
                        end
                    end
                end
                OP_START: n_flags[EV_START] = 1'b1;
                OP_STOP:  n_flags[EV_STOP]  = 1'b1;
                OP_WRITE: ;
            endcase

            unique case (r_state)
                ST_IDLE: begin
                    if (n_flags[EV_START]) begin
                        n_flags   = '0;
                        n_pos     = '0;
                        n_cur     = w_note0;
                        n_tone    = w_note0.freq;
                        n_tmr     = '0;
                        n_tmr_run = 1'b1;
                        n_state   = ST_PLAYING;
                    end
                end
                ST_PLAYING: begin
                    if (n_flags[EV_TMO]) begin
                        n_flags[EV_TMO] = 1'b0;
                        n_tmr_run       = 1'b0;
                        if (CW'(r_pos) != CW'(r_note_count - CNT_W'(1))) begin
                            n_pos = w_next_addr;
                            n_cur = w_next;
                        end else begin
                            n_flags[EV_END] = 1'b1;
                        end
                        n_state = ST_BETWEEN;
                    end else if (n_flags[EV_STOP]) begin
                        n_tone           = '0;
                        n_flags[EV_STOP] = 1'b0;
                        n_tmr_run        = 1'b0;
                        n_state          = ST_IDLE;
                    end
                end
                ST_BETWEEN: begin
                    if (!n_flags[EV_END]) begin
                        n_tone    = r_cur.freq;
                        n_tmr     = '0;
                        n_tmr_run = 1'b1;
                        n_state   = ST_PLAYING;
                    end else begin
                        n_flags[EV_START] = 1'b0;
                        n_tmr_run         = 1'b0;
                        n_state           = ST_IDLE;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // Build the result from the state after the transition
    always_comb begin
        w_res.tone_frequency = n_tone;
        w_res.note_position  = IDX_W'(n_pos);
        unique case (n_state)
            ST_PLAYING: w_res.player_state = PS_PLAYING;
            ST_BETWEEN: w_res.player_state = PS_BETWEEN;
            default:    w_res.player_state = PS_IDLE;
        endcase
    end

    // Prefetch the note after the new position
    assign w_raddr = i_rst_n ? (n_pos + AW'(1)) : AW'(1);

    mns_ram #(
        .WIDTH (2 * FREQ_W),
        .DEPTH (MAX_NOTES)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_idx),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    mns_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc),
        .i_data  (w_res),
        .o_ready (w_buf_rdy),
        .o_res   (o_res)
    );

    // Hold note 0 copy and the write seen by this cycle's read
    always_ff @(posedge i_clk) begin
        if (w_wr && (w_idx == '0)) begin
            r_note0 <= w_wdata;
        end
        r_fwd_data <= w_wdata;
        r_cur      <= n_cur;
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= w_wr && (w_idx == w_raddr);
        end
    end

    // Advance the player state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_flags      <= '0;
            r_pos        <= '0;
            r_tone       <= '0;
            r_tmr        <= '0;
            r_tmr_run    <= 1'b0;
            r_note_count <= CNT_W'(1);
        end else begin
            r_state   <= n_state;
            r_flags   <= n_flags;
            r_pos     <= n_pos;
            r_tone    <= n_tone;
            r_tmr     <= n_tmr;
            r_tmr_run <= n_tmr_run;
            if (i_cfg_we) begin
                r_note_count <= i_cfg_data;
            end
        end
    end

    `MNS_ASSERT(a_tmr_playing, i_clk, i_rst_n, !r_tmr_run || (r_state == ST_PLAYING), "stray timer")
    `MNS_ASSERT(a_tmo_taken, i_clk, i_rst_n, !r_flags[EV_TMO], "timeout flag left pending")
    `MNS_ASSERT_NEXT(a_acc_result, i_clk, i_rst_n, w_acc, o_res.valid, "item left no result")

endmodule

`default_nettype wire

>>> test/mns_note_checker.sv
module mns_note_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [mns_pkg::CNT_W-1:0] i_cfg_data,
    mns_note_if                            i_note,
    mns_result_if                          i_res,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mns_pkg::*;

    localparam int SHOWN_MAX = 10;

    // Mirror of the player: note tables, melody length, FSM, timer
    logic [FREQ_W-1:0] freq_tab [MAX_NOTES_DEF];
    logic [DUR_W-1:0]  dur_tab  [MAX_NOTES_DEF];
    logic [CNT_W-1:0]  melody_len;
    t_state            player;
    logic [IDX_W-1:0]  cur_pos;
    logic [FREQ_W-1:0] cur_freq;
    logic [DUR_W-1:0]  cur_dur;
    logic [FREQ_W-1:0] tone;
    logic [3:0]        flags;
    logic [DUR_W-1:0]  elapsed_ms;
    logic              timer_on;

    // Reports owed by the block, oldest first
    t_result_item queued_reports [$];
    int           bad_reports;

    task automatic load_note(input logic [IDX_W-1:0] pos);
        cur_freq = freq_tab[pos];
        cur_dur  = dur_tab[pos];
    endtask

    // Apply one item's event, fire at most one transition, report the outputs
    task automatic step_player(input t_note_item it, output t_result_item rep);
        logic [CNT_W-1:0] last_pos;
        last_pos = melody_len - 1'b1;

        case (it.operation)
            OP_TICK: begin
                if (timer_on) begin
                    if (elapsed_ms != '1) elapsed_ms++;
                    if (elapsed_ms >= cur_dur) begin
                        flags[EV_TMO] = 1'b1;
                        timer_on      = 1'b0;
                    end
                end
            end
            OP_START: flags[EV_START] = 1'b1;
            OP_STOP:  flags[EV_STOP]  = 1'b1;
            default: begin
                freq_tab[it.note_index] = it.note_frequency;
                dur_tab[it.note_index]  = it.note_duration;
            end
        endcase

        case (player)
            ST_IDLE: begin
                if (flags[EV_START]) begin
                    flags      = '0;
                    cur_pos    = '0;
                    load_note('0);
                    tone       = cur_freq;
                    elapsed_ms = '0;
                    timer_on   = 1'b1;
                    player     = ST_PLAYING;
                end
            end
            ST_PLAYING: begin
                if (flags[EV_TMO]) begin
                    flags[EV_TMO] = 1'b0;
                    timer_on      = 1'b0;
                    if ({1'b0, cur_pos} != last_pos) begin
                        cur_pos = cur_pos + 1'b1;
                        load_note(cur_pos);
                    end else begin
                        flags[EV_END] = 1'b1;
                    end
                    player = ST_BETWEEN;
                end else if (flags[EV_STOP]) begin
                    tone           = '0;
                    flags[EV_STOP] = 1'b0;
                    timer_on       = 1'b0;
                    player         = ST_IDLE;
                end
            end
            default: begin
                if (!flags[EV_END]) begin
                    tone       = cur_freq;
                    elapsed_ms = '0;
                    timer_on   = 1'b1;
                    player     = ST_PLAYING;
                end else begin
                    // melody end: the last tone keeps sounding
                    flags[EV_START] = 1'b0;
                    timer_on        = 1'b0;
                    player          = ST_IDLE;
                end
            end
        endcase

        rep.tone_frequency = tone;
        case (player)
            ST_IDLE:    rep.player_state = PS_IDLE;
            ST_PLAYING: rep.player_state = PS_PLAYING;
            default:    rep.player_state = PS_BETWEEN;
        endcase
        rep.note_position = cur_pos;
    endtask

    // Watch config writes and both channels at each edge
    always @(posedge i_clk) begin : watch_channels
        t_result_item want;
        t_result_item got;
        if (!i_rst_n) begin
            melody_len = 11'd1;
            player     = ST_IDLE;
            cur_pos    = '0;
            cur_freq   = '0;
            cur_dur    = '0;
            tone       = '0;
            flags      = '0;
            elapsed_ms = '0;
            timer_on   = 1'b0;
            queued_reports.delete();
        end else begin
            if (i_cfg_we) melody_len = i_cfg_data;

            if (i_note.valid && i_note.ready) begin
                step_player(i_note.payload, want);
                queued_reports.push_back(want);
            end

            if (i_res.valid && i_res.ready) begin
                got = i_res.payload;
                if (queued_reports.size() == 0) begin
                    bad_reports++;
                    if (bad_reports <= SHOWN_MAX)
                        $display("unexpected report: tone %0d state %0d position %0d",
                                 got.tone_frequency, got.player_state, got.note_position);
                end else begin
                    want = queued_reports.pop_front();
                    if (got.tone_frequency !== want.tone_frequency ||
                        got.player_state   !== want.player_state   ||
                        got.note_position  !== want.note_position) begin
                        bad_reports++;
                        if (bad_reports <= SHOWN_MAX)
                            $display({"report mismatch: expected tone %0d state %0d ",
                                      "position %0d, got tone %0d state %0d position %0d"},
                                     want.tone_frequency, want.player_state,
                                     want.note_position, got.tone_frequency,
                                     got.player_state, got.note_position);
                    end
                end
            end
        end
        o_pending    <= queued_reports.size();
        o_fail_count <= bad_reports;
    end

endmodule

>>> test/tb_melody_note_sequencer_unit.sv
module tb_melody_note_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mns_pkg::*;

    localparam int HOLD_CYCLES  = 64;
    localparam int PHASE_ITEMS  = 130;
    localparam int PHASE_COUNT  = 10;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_data;
    int               fail_count;
    int               pending;

    mns_note_if   note_ch ();
    mns_result_if res_ch ();

    // Drain side and sender controls
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    // Which table entries hold data, and how far the position can have moved
    bit               note_set [MAX_NOTES_DEF];
    int               prefix    = 0;
    int               pos_bound = 0;
    logic [CNT_W-1:0] melody_len = 11'd1;

    logic [CNT_W-1:0] lengths [PHASE_COUNT] =
        '{11'd1, 11'd1024, 11'd3, 11'd2047, 11'd2, 11'd0, 11'd5, 11'd1025, 11'd4, 11'd1};

    melody_note_sequencer_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_note     (note_ch),
        .o_res      (res_ch)
    );

    mns_note_checker checker_u (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_note       (note_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    function automatic t_note_item mk(input t_op op, input int idx, input int freq,
                                      input int dur);
        t_note_item it;
        it.operation      = op;
        it.note_index     = idx[IDX_W-1:0];
        it.note_frequency = freq[FREQ_W-1:0];
        it.note_duration  = dur[DUR_W-1:0];
        return it;
    endfunction

    // Highest position one more timeout could load in this phase
    function automatic int next_bound();
        int lim;
        lim = (melody_len >= 1 && melody_len <= MAX_NOTES_DEF) ? int'(melody_len) - 1
                                                                : MAX_NOTES_DEF - 1;
        return (pos_bound + 1 < lim) ? pos_bound + 1 : lim;
    endfunction

    function automatic t_note_item pick_item();
        t_note_item it;
        int         roll;
        it   = mk(OP_TICK, $urandom_range(0, 1023), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
        roll = $urandom_range(0, 99);
        if (roll < 15)
            it.operation = OP_START;
        else if (roll < 25)
            it.operation = OP_STOP;
        else if (roll < 50)
            it.operation = OP_WRITE;

        // Swap a tick that could reach an empty entry for a write that fills it
        if (it.operation == OP_TICK && next_bound() >= prefix) begin
            it.operation  = OP_WRITE;
            it.note_index = prefix[IDX_W-1:0];
        end else if (it.operation == OP_WRITE && prefix < MAX_NOTES_DEF &&
                     $urandom_range(0, 1) == 1) begin
            it.note_index = prefix[IDX_W-1:0];
        end

        if (it.operation == OP_WRITE) begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                it.note_frequency = '0;
            else if (roll == 1)
                it.note_frequency = '1;
            // Keep most notes short so melodies move on
            roll = $urandom_range(0, 9);
            if (roll < 7)
                it.note_duration = DUR_W'($urandom_range(0, 3));
            else if (roll < 9)
                it.note_duration = DUR_W'($urandom_range(4, 12));
        end
        return it;
    endfunction

    // Offer one item and hold it until accepted
    task automatic push_note(input t_note_item it);
        int gap;
        if (it.operation == OP_WRITE) begin
            note_set[it.note_index] = 1'b1;
            while (prefix < MAX_NOTES_DEF && note_set[prefix]) prefix++;
        end else if (it.operation == OP_TICK) begin
            pos_bound = next_bound();
        end

        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            note_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note_ch.valid   <= 1'b1;
        note_ch.payload <= it;
        @(posedge clk);
        while (!note_ch.ready) @(posedge clk);
    endtask

    // Stop offering and wait for every owed report
    task automatic wait_drained();
        note_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Park the player in idle, then load a new melody length
    task automatic set_length(input logic [CNT_W-1:0] len);
        repeat (5) push_note(mk(OP_STOP, 0, 0, 0));
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we     <= 1'b0;
        melody_len = len;
        pos_bound  = 0;
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin : drain_side
        int n;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                n = $urandom_range(1, 4);
                repeat (n) @(posedge clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int p;
        note_ch.valid   <= 1'b0;
        note_ch.payload <= '0;
        cfg_we          <= 1'b0;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Note 0 first: any start loads it
        push_note(mk(OP_WRITE, 0, 16'hFFFF, 0));
        push_note(mk(OP_WRITE, 1023, 0, 16'hFFFF));
        push_note(mk(OP_WRITE, 1, 16'h1234, 1));
        // Tick with the timer stopped, stop lingering in idle
        push_note(mk(OP_TICK, 0, 0, 0));
        push_note(mk(OP_STOP, 0, 0, 0));
        // Zero duration times out on the first tick, melody end keeps the tone
        push_note(mk(OP_START, 0, 0, 0));
        push_note(mk(OP_TICK, 0, 0, 0));
        push_note(mk(OP_TICK, 0, 0, 0));
        // Start while playing survives the stop and restarts at note 0
        push_note(mk(OP_START, 0, 0, 0));
        push_note(mk(OP_START, 0, 0, 0));
        push_note(mk(OP_STOP, 0, 0, 0));
        push_note(mk(OP_TICK, 0, 0, 0));
        push_note(mk(OP_TICK, 0, 0, 0));
        // Start arriving at melody end is dropped
        push_note(mk(OP_START, 0, 0, 0));
        push_note(mk(OP_TICK, 0, 0, 0));

        // Two notes: advance, stop between notes, timeout wins over stop
        set_length(11'd2);
        push_note(mk(OP_START, 0, 0, 0));
        push_note(mk(OP_TICK, 0, 0, 0));
        push_note(mk(OP_STOP, 0, 0, 0));
        push_note(mk(OP_TICK, 0, 0, 0));
        push_note(mk(OP_TICK, 0, 0, 0));

        for (p = 0; p < PHASE_COUNT; p++) begin
            // Run the last phase without idling
            if (p == PHASE_COUNT - 1) idle_on = 1'b0;
            set_length(lengths[p]);
            if (p == 2) hold_req = 1'b1;
            repeat (PHASE_ITEMS) push_note(pick_item());
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("melody_note_sequencer_unit verification clean");
        else
            $display("melody_note_sequencer_unit verification failed");
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #(40_000_000);
        $display("melody_note_sequencer_unit verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mns_pkg.sv
rtl/mns_if.sv
rtl/mns_ram.sv
rtl/mns_out_buf.sv
rtl/melody_note_sequencer_unit.sv
test/mns_note_checker.sv
test/tb_melody_note_sequencer_unit.sv
